[hw/rtl/ebcc_pkg.sv]
// Shared types, constants and tables for the extent bitmap claim checker.
// Depends on nothing; the RAM, byte merge, sequencer and top files refer to it by scoped names.
`default_nettype none

package ebcc_pkg;

	localparam int PARTITIONS           = 4;
	localparam int BLOCKS_PER_PARTITION = 65536;
	localparam int BYTES_PER_PART       = (BLOCKS_PER_PARTITION + 7) / 8;
	localparam int MAP_BYTES            = PARTITIONS * BYTES_PER_PART;

	localparam int PART_W     = $clog2(PARTITIONS);
	localparam int BYTE_IX_W  = $clog2(BYTES_PER_PART);
	localparam int MAP_ADDR_W = $clog2(MAP_BYTES);
	localparam int BLK_W      = $clog2(BLOCKS_PER_PARTITION);

	localparam int CFG_IX_W   = 3;
	localparam int CFG_DATA_W = 17;
	localparam int LEN_W      = 17;

	// Configuration register indexes.
	localparam logic [CFG_IX_W-1:0] CFG_PARTITION_COUNT = 3'd0;
	localparam logic [CFG_IX_W-1:0] CFG_PART_LEN_0      = 3'd1;
	localparam logic [CFG_IX_W-1:0] CFG_PART_LEN_1      = 3'd2;
	localparam logic [CFG_IX_W-1:0] CFG_PART_LEN_2      = 3'd3;
	localparam logic [CFG_IX_W-1:0] CFG_PART_LEN_3      = 3'd4;
	localparam logic [CFG_IX_W-1:0] CFG_MAP_PRESENT     = 3'd5;
	localparam logic [CFG_IX_W-1:0] CFG_BLOCK_SHIFT     = 3'd6;

	// Result status codes.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_OVERLAP   = 2'd1;
	localparam logic [1:0] STATUS_BAD_START = 2'd2;
	localparam logic [1:0] STATUS_BAD_PART  = 2'd3;

	// Bit select table for the blocks inside one bitmap byte.
	localparam logic [7:0] BIT_SEL [8] = '{8'd1, 8'd2, 8'd4, 8'd8,
		8'd16, 8'd32, 8'd64, 8'd128};

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_CHECK = 6'b000100,
		ST_PLAN  = 6'b001000,
		ST_RUN   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	typedef struct packed {
		logic [2:0]                       partition_count;
		logic [PARTITIONS-1:0][LEN_W-1:0] part_len;
		logic [PARTITIONS-1:0]            map_present;
		logic [3:0]                       block_shift;
	} cfg_t;

	typedef struct packed {
		logic                  en;
		logic [MAP_ADDR_W-1:0] addr;
		logic [7:0]            data;
	} ram_wr_t;

	typedef struct packed {
		logic                  en;
		logic [MAP_ADDR_W-1:0] addr;
	} ram_rd_t;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] lo;
		logic [2:0] hi;
	} mrg_req_t;

	typedef struct packed {
		logic [7:0] new_data;
		logic       any;
		logic [3:0] count;
		logic [2:0] last_bit;
	} mrg_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/ebcc_if.sv]
// Valid/ready channel interfaces for claim beats in and result beats out.
// Depends on nothing but the fixed field widths of the block.
`default_nettype none

interface ebcc_claim_if;
	logic        valid;
	logic        ready;
	logic [15:0] partition;
	logic [31:0] start_block;
	logic [31:0] extent_bytes;

	modport source (output valid, output partition, output start_block,
		output extent_bytes, input ready);
	modport sink (input valid, input partition, input start_block,
		input extent_bytes, output ready);
endinterface

interface ebcc_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] error_sector;
	logic [16:0] expected_limit;
	logic [31:0] found_value;
	logic [16:0] overlap_count;
	logic        truncated;

	modport source (output valid, output status, output error_sector,
		output expected_limit, output found_value, output overlap_count,
		output truncated, input ready);
	modport sink (input valid, input status, input error_sector,
		input expected_limit, input found_value, input overlap_count,
		input truncated, output ready);
endinterface

`default_nettype wire

[hw/rtl/ebcc_map_ram.sv]
// Free-space bitmap storage: one write port and one registered read port, one byte wide.
// Depends on ebcc_pkg for the depth and the port structs.
`default_nettype none

module ebcc_map_ram (
	input  wire                      clk,
	input  wire ebcc_pkg::ram_wr_t   wr,
	input  wire ebcc_pkg::ram_rd_t   rd,
	output logic [7:0]               rd_data
);

	logic [7:0] mem [ebcc_pkg::MAP_BYTES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ebcc_byte_merge.sv]
// Byte-wide claim unit: clears the claimed bits of one bitmap byte and reports overlaps.
// Depends on ebcc_pkg for the request and response structs and the bit select table.
`default_nettype none

module ebcc_byte_merge (
	input  wire ebcc_pkg::mrg_req_t req,
	output ebcc_pkg::mrg_rsp_t      rsp
);

	logic [7:0] mask;
	logic [7:0] hit;
	logic [3:0] cnt;
	logic [2:0] last;

	always_comb begin
		mask = '0;
		for (int i = 0; i < 8; i++) begin
			if ((3'(i) >= req.lo) && (3'(i) <= req.hi)) begin
				mask = mask | ebcc_pkg::BIT_SEL[i];
			end
		end
		// A claimed block whose bit is already clear is an overlap.
		hit  = mask & ~req.data;
		cnt  = '0;
		last = '0;
		for (int i = 0; i < 8; i++) begin
			cnt = cnt + 4'(hit[i]);
			if (hit[i]) begin
				last = 3'(i);
			end
		end
		rsp.new_data = req.data & ~mask;
		rsp.any      = |hit;
		rsp.count    = cnt;
		rsp.last_bit = last;
	end

endmodule

`default_nettype wire

[hw/rtl/ebcc_seq.sv]
// Sequencer of the claim checker: range checks, extent planning and the byte walk.
// Depends on ebcc_pkg and the channel interfaces; it drives the ports of ebcc_map_ram and ebcc_byte_merge.
`default_nettype none

module ebcc_seq (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire ebcc_pkg::cfg_t        cfg,
	ebcc_claim_if.sink                 claim,
	ebcc_result_if.source              result,
	output ebcc_pkg::ram_wr_t          ram_wr,
	output ebcc_pkg::ram_rd_t          ram_rd,
	input  wire [7:0]                  ram_rd_data,
	output ebcc_pkg::mrg_req_t         mrg_req,
	input  wire ebcc_pkg::mrg_rsp_t    mrg_rsp
);

	localparam int PW = ebcc_pkg::PART_W;
	localparam int BW = ebcc_pkg::BYTE_IX_W;
	localparam int KW = ebcc_pkg::BLK_W;
	localparam int LW = ebcc_pkg::LEN_W;
	localparam int AW = ebcc_pkg::MAP_ADDR_W;

	ebcc_pkg::state_t state_q;

	logic [AW-1:0] clr_q;
	logic          issue_q;
	logic          valid_s1;
	logic          out_valid_q;

	logic [15:0]   ptn_q;
	logic [31:0]   start_q;
	logic [31:0]   bytes_q;
	logic [23:0]   nblk_q;
	logic [LW-1:0] avail_q;
	logic [KW-1:0] last_blk_q;
	logic [BW-1:0] rd_byte_q;
	logic [BW-1:0] byte_s1;

	logic [1:0]    status_q;
	logic [31:0]   sector_q;
	logic [LW-1:0] expected_q;
	logic [31:0]   found_q;
	logic [LW-1:0] ovl_q;
	logic          trunc_q;

	logic [1:0]    out_status_q;
	logic [31:0]   out_sector_q;
	logic [LW-1:0] out_expected_q;
	logic [31:0]   out_found_q;
	logic [LW-1:0] out_ovl_q;
	logic          out_trunc_q;

	logic [PW-1:0] part_sel;
	logic [2:0]    count_eff;
	logic [LW-1:0] len_raw;
	logic [LW-1:0] len_eff;
	logic          bad_part;
	logic          bad_start;
	logic          map_on;
	logic [22:0]   quot;
	logic          rem_nz;
	logic [23:0]   nblk_w;
	logic [LW-1:0] avail_w;
	logic          clip;
	logic [LW-1:0] n_w;
	logic [LW-1:0] last_sum;
	logic [BW-1:0] first_byte;
	logic [BW-1:0] last_byte;
	logic          rd_last;
	logic          out_load;

	assign part_sel   = ptn_q[PW-1:0];
	assign count_eff  = (cfg.partition_count > 3'(ebcc_pkg::PARTITIONS)) ?
		3'(ebcc_pkg::PARTITIONS) : cfg.partition_count;
	assign len_raw    = cfg.part_len[part_sel];
	assign len_eff    = (len_raw > LW'(ebcc_pkg::BLOCKS_PER_PARTITION)) ?
		LW'(ebcc_pkg::BLOCKS_PER_PARTITION) : len_raw;
	assign bad_part   = ptn_q >= {13'b0, count_eff};
	assign bad_start  = start_q >= {15'b0, len_eff};
	assign map_on     = cfg.map_present[part_sel];

	// Round the byte length up to whole blocks; the shift is clamped to 9..12.
	always_comb begin
		case (cfg.block_shift) inside
			[4'd0:4'd9]: begin
				quot   = bytes_q[31:9];
				rem_nz = |bytes_q[8:0];
			end
			4'd10: begin
				quot   = {1'b0, bytes_q[31:10]};
				rem_nz = |bytes_q[9:0];
			end
			4'd11: begin
				quot   = {2'b0, bytes_q[31:11]};
				rem_nz = |bytes_q[10:0];
			end
			default: begin
				quot   = {3'b0, bytes_q[31:12]};
				rem_nz = |bytes_q[11:0];
			end
		endcase
	end

	assign nblk_w   = {1'b0, quot} + {23'b0, rem_nz};
	// Only used once the start block is known to be inside the partition.
	assign avail_w  = len_eff - start_q[LW-1:0];
	assign clip     = nblk_q > {7'b0, avail_q};
	assign n_w      = clip ? avail_q : nblk_q[LW-1:0];
	assign last_sum = {1'b0, start_q[KW-1:0]} + n_w - LW'(1);

	assign first_byte = start_q[KW-1:3];
	assign last_byte  = last_blk_q[KW-1:3];
	assign rd_last    = rd_byte_q == last_byte;
	assign out_load   = (state_q == ebcc_pkg::ST_DONE) && (!out_valid_q || result.ready);

	assign claim.ready = state_q == ebcc_pkg::ST_IDLE;

	assign ram_rd.en   = (state_q == ebcc_pkg::ST_RUN) && issue_q;
	assign ram_rd.addr = {part_sel, rd_byte_q};

	always_comb begin
		if (state_q == ebcc_pkg::ST_CLEAR) begin
			ram_wr.en   = 1'b1;
			ram_wr.addr = clr_q;
			ram_wr.data = 8'hFF;
		end else begin
			ram_wr.en   = valid_s1;
			ram_wr.addr = {part_sel, byte_s1};
			ram_wr.data = mrg_rsp.new_data;
		end
	end

	assign mrg_req.data = ram_rd_data;
	assign mrg_req.lo   = (byte_s1 == first_byte) ? start_q[2:0] : 3'd0;
	assign mrg_req.hi   = (byte_s1 == last_byte) ? last_blk_q[2:0] : 3'd7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ebcc_pkg::ST_CLEAR;
			clr_q       <= '0;
			issue_q     <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ebcc_pkg::ST_RUN) && issue_q;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ebcc_pkg::ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= ebcc_pkg::ST_IDLE;
					end
				end
				ebcc_pkg::ST_IDLE: begin
					if (claim.valid) begin
						state_q <= ebcc_pkg::ST_CHECK;
					end
				end
				ebcc_pkg::ST_CHECK: begin
					if (bad_part || bad_start || !map_on) begin
						state_q <= ebcc_pkg::ST_DONE;
					end else begin
						state_q <= ebcc_pkg::ST_PLAN;
					end
				end
				ebcc_pkg::ST_PLAN: begin
					if (n_w == '0) begin
						state_q <= ebcc_pkg::ST_DONE;
					end else begin
						issue_q <= 1'b1;
						state_q <= ebcc_pkg::ST_RUN;
					end
				end
				ebcc_pkg::ST_RUN: begin
					if (issue_q && rd_last) begin
						issue_q <= 1'b0;
					end
					if (valid_s1 && (byte_s1 == last_byte)) begin
						state_q <= ebcc_pkg::ST_DONE;
					end
				end
				ebcc_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= ebcc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ebcc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		byte_s1 <= rd_byte_q;
		if (claim.valid && claim.ready) begin
			ptn_q   <= claim.partition;
			start_q <= claim.start_block;
			bytes_q <= claim.extent_bytes;
		end
		case (state_q)
			ebcc_pkg::ST_CHECK: begin
				nblk_q  <= nblk_w;
				avail_q <= avail_w;
				ovl_q   <= '0;
				trunc_q <= 1'b0;
				if (bad_part) begin
					status_q   <= ebcc_pkg::STATUS_BAD_PART;
					sector_q   <= start_q;
					expected_q <= {14'b0, count_eff};
					found_q    <= {16'b0, ptn_q};
				end else if (bad_start) begin
					status_q   <= ebcc_pkg::STATUS_BAD_START;
					sector_q   <= start_q;
					expected_q <= len_eff;
					found_q    <= start_q;
				end else begin
					status_q   <= ebcc_pkg::STATUS_OK;
					sector_q   <= '0;
					expected_q <= '0;
					found_q    <= '0;
				end
			end
			ebcc_pkg::ST_PLAN: begin
				trunc_q    <= clip;
				last_blk_q <= last_sum[KW-1:0];
				rd_byte_q  <= first_byte;
			end
			ebcc_pkg::ST_RUN: begin
				if (issue_q && !rd_last) begin
					rd_byte_q <= rd_byte_q + BW'(1);
				end
				if (valid_s1 && mrg_rsp.any) begin
					status_q <= ebcc_pkg::STATUS_OVERLAP;
					sector_q <= {16'b0, byte_s1, mrg_rsp.last_bit};
					ovl_q    <= ovl_q + LW'(mrg_rsp.count);
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_status_q   <= status_q;
			out_sector_q   <= sector_q;
			out_expected_q <= expected_q;
			out_found_q    <= found_q;
			out_ovl_q      <= ovl_q;
			out_trunc_q    <= trunc_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.status         = out_status_q;
	assign result.error_sector   = out_sector_q;
	assign result.expected_limit = out_expected_q;
	assign result.found_value    = out_found_q;
	assign result.overlap_count  = out_ovl_q;
	assign result.truncated      = out_trunc_q;

`ifndef SYNTHESIS
	a_ram_no_same_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr.en && ram_rd.en) |-> (ram_wr.addr != ram_rd.addr))
		else $error("bitmap read and write hit the same byte");

	a_s1_only_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ebcc_pkg::ST_RUN))
		else $error("byte merge stage active outside the walk");

	a_overlap_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.status == ebcc_pkg::STATUS_OVERLAP))
		|-> (result.overlap_count != '0))
		else $error("overlap status without an overlap count");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && ((result.status == ebcc_pkg::STATUS_BAD_START) ||
		(result.status == ebcc_pkg::STATUS_BAD_PART)))
		|-> ((result.overlap_count == '0) && !result.truncated))
		else $error("rejected claim reports walk results");
`endif

endmodule

`default_nettype wire

[hw/rtl/extent_bitmap_claim_checker_core.sv]
// Extent bitmap claim checker top level; uses ebcc_pkg, ebcc_if, ebcc_map_ram,
// ebcc_byte_merge and ebcc_seq. A rejected or map-less claim goes from the check state
// to done, an empty extent goes by way of planning, and a walk adds the run state, which
// moves one bitmap byte (eight blocks) per cycle through the read-modify-write port.
// One claim is in flight at a time; the next beat is taken in the cycle after the result loads.
// Reset starts a pass that sets the whole bitmap all free; claims wait, config is taken.
`default_nettype none

module extent_bitmap_claim_checker_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	ebcc_claim_if.sink                          claim,
	ebcc_result_if.source                       result,
	input  wire                                 cfg_we,
	input  wire [ebcc_pkg::CFG_IX_W-1:0]        cfg_index,
	input  wire [ebcc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	// Configuration registers. The partition count, mask and shift keep only their low
	// bits; clamping of out-of-range values happens where they are used, so that the
	// stored value is exactly what was written.
	logic [2:0]                                                   part_count_q;
	logic [ebcc_pkg::PARTITIONS-1:0][ebcc_pkg::LEN_W-1:0]         part_len_q;
	logic [ebcc_pkg::PARTITIONS-1:0]                              map_present_q;
	logic [3:0]                                                   block_shift_q;

	ebcc_pkg::cfg_t     cfg;
	ebcc_pkg::ram_wr_t  ram_wr;
	ebcc_pkg::ram_rd_t  ram_rd;
	logic [7:0]         ram_rd_data;
	ebcc_pkg::mrg_req_t mrg_req;
	ebcc_pkg::mrg_rsp_t mrg_rsp;

	// A write to an index past the last register is simply dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_count_q  <= '0;
			part_len_q    <= '0;
			map_present_q <= '1;
			block_shift_q <= 4'd11;
		end else if (cfg_we) begin
			case (cfg_index)
				ebcc_pkg::CFG_PARTITION_COUNT: part_count_q     <= cfg_wdata[2:0];
				ebcc_pkg::CFG_PART_LEN_0:      part_len_q[0]    <= cfg_wdata;
				ebcc_pkg::CFG_PART_LEN_1:      part_len_q[1]    <= cfg_wdata;
				ebcc_pkg::CFG_PART_LEN_2:      part_len_q[2]    <= cfg_wdata;
				ebcc_pkg::CFG_PART_LEN_3:      part_len_q[3]    <= cfg_wdata;
				ebcc_pkg::CFG_MAP_PRESENT:     map_present_q    <= cfg_wdata[3:0];
				ebcc_pkg::CFG_BLOCK_SHIFT:     block_shift_q    <= cfg_wdata[3:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.partition_count = part_count_q;
	assign cfg.part_len        = part_len_q;
	assign cfg.map_present     = map_present_q;
	assign cfg.block_shift     = block_shift_q;

	// The bitmap: one byte per eight blocks, partition number in the top address bits.
	// Its contents are set by the sequencer's clearing pass, not by reset.
	ebcc_map_ram u_map_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd      (ram_rd),
		.rd_data (ram_rd_data)
	);

	// The byte unit: given one bitmap byte and the range of claimed bit positions
	// in it, it returns the byte with those bits cleared, the number of claimed bits that
	// were already clear and the highest such bit.
	ebcc_byte_merge u_byte_merge (
		.req (mrg_req),
		.rsp (mrg_rsp)
	);

	// The sequencer checks the partition, start block and map presence, rounds the byte length
	// up to blocks, clips it at the partition end, then walks the extent a byte at a time:
	// the read of the next byte overlaps the write-back of the current one. The result sits
	// in an output register, so the next claim beat can be taken while the previous result
	// beat is still waiting.
	ebcc_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.claim       (claim),
		.result      (result),
		.ram_wr      (ram_wr),
		.ram_rd      (ram_rd),
		.ram_rd_data (ram_rd_data),
		.mrg_req     (mrg_req),
		.mrg_rsp     (mrg_rsp)
	);

endmodule

`default_nettype wire
